>>> rtl/core/pfe_pkg.sv
// shared types, character codes and helper functions for the postfix evaluator
// no dependencies; used by pfe_dp, pfe_ctrl and the top level
`default_nettype none

package pfe_pkg;

    // ascii codes of the accepted characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] DIGIT_MAX = 8'd9;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNKNOWN   = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_ADD,
        TK_SUB,
        TK_MUL,
        TK_DIV,
        TK_BAD
    } t_tok_kind;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // latch token and last flag
        logic load_digit; // digit value into result register
        logic unknown;    // flag unknown character, start skipping
        logic pop;        // pop top of stack into read register
        logic load_b;     // right operand from read register
        logic load_a;     // left operand from read register
        logic load_top;   // final value from read register
        logic exec;       // run add, sub, multiply or start the divide
        logic mul_fin;    // scale and saturate the product
        logic div_fin;    // sign and saturate the quotient
        logic push;       // push result register
        logic out_load;   // move final word to the output register, clear state
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        t_tok_kind kind;
        logic      last;
        logic      skipping;
        logic      b_zero;
        logic      div_busy;
        logic      div_done;
        logic      out_full;
        logic      sp_empty;
        logic      sp_full;
    } t_dp_sts;

    function automatic t_tok_kind decode_token(input logic [7:0] tok);
        logic [7:0] off;
        t_tok_kind  kind;
        begin
            off = tok - CH_ZERO;
            priority if (tok >= CH_ZERO && off <= DIGIT_MAX) begin
                kind = TK_DIGIT;
            end else if (tok == CH_PLUS) begin
                kind = TK_ADD;
            end else if (tok == CH_MINUS) begin
                kind = TK_SUB;
            end else if (tok == CH_STAR) begin
                kind = TK_MUL;
            end else if (tok == CH_SLASH) begin
                kind = TK_DIV;
            end else begin
                kind = TK_BAD;
            end
            return kind;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            priority if (v > SAT_MAX) begin
                r = SAT_MAX[31:0];
            end else if (v < SAT_MIN) begin
                r = SAT_MIN[31:0];
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pfe_div.sv
// iterative unsigned restoring divider, one quotient bit per cycle
// no package dependencies; instantiated by pfe_dp
`default_nettype none

module pfe_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [32+FRAC_BITS-1:0] i_dividend,
    input  wire logic [31:0]             i_divisor,
    output logic      [32+FRAC_BITS-1:0] o_quotient,
    output logic                         o_busy,
    output logic                         o_done
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [31:0]   r_div;

    logic [32:0] w_sh;
    logic [33:0] w_diff;
    logic        w_ge;

    // shift in the next dividend bit and try the subtract
    assign w_sh   = {r_rem, r_quo[DW-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_div};
    assign w_ge   = ~w_diff[33];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_sh[31:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

`default_nettype wire

>>> rtl/core/pfe_dp.sv
// datapath: operand stack memory, stack pointer, sticky status, alu and output register
// depends on pfe_pkg and pfe_div
`default_nettype none

module pfe_dp #(
    parameter int STACK_DEPTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [7:0]         i_token,
    input  wire logic               i_last,
    input  wire pfe_pkg::t_dp_cmd   i_cmd,
    output pfe_pkg::t_dp_sts        o_sts,
    output logic signed [31:0]      o_value,
    output logic [2:0]              o_status,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int DW = 32 + FRAC_BITS;
    localparam logic signed [63:0] BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    logic signed [31:0] r_mem [STACK_DEPTH];

    // control state
    logic [SPW-1:0] r_sp;
    logic [2:0]     r_err;
    logic           r_skip;
    logic           r_out_valid;

    // payload
    logic [7:0]         r_tok;
    logic               r_last;
    logic               r_empty;
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic signed [31:0] r_res;
    logic signed [63:0] r_prod;
    logic               r_neg;
    logic signed [31:0] r_out_value;
    logic [2:0]         r_out_status;

    pfe_pkg::t_tok_kind w_kind;
    logic               w_sp_empty;
    logic               w_sp_full;
    logic [SPW-1:0]     w_spm1;
    logic [7:0]         w_off;
    logic               w_b_zero;
    logic               w_flag_en;
    logic [2:0]         w_flag_code;
    logic [31:0]        w_mag_a;
    logic [31:0]        w_mag_b;
    logic               w_div_start;
    logic [DW-1:0]      w_quo;
    logic               w_div_busy;
    logic               w_div_done;
    logic signed [63:0] w_mul_sh;
    logic signed [63:0] w_qs;

    assign w_kind     = pfe_pkg::decode_token(r_tok);
    assign w_sp_empty = (r_sp == '0);
    assign w_sp_full  = (r_sp == SPW'(STACK_DEPTH));
    assign w_spm1     = r_sp - SPW'(1);
    assign w_off      = r_tok - pfe_pkg::CH_ZERO;
    assign w_b_zero   = (r_b == '0);

    // at most one error source is active in any cycle
    always_comb begin
        w_flag_en   = 1'b0;
        w_flag_code = pfe_pkg::ST_OK;
        priority if (i_cmd.unknown) begin
            w_flag_en   = 1'b1;
            w_flag_code = pfe_pkg::ST_UNKNOWN;
        end else if (i_cmd.pop && w_sp_empty) begin
            w_flag_en   = 1'b1;
            w_flag_code = pfe_pkg::ST_UNDERFLOW;
        end else if (i_cmd.exec && w_kind == pfe_pkg::TK_DIV && w_b_zero) begin
            w_flag_en   = 1'b1;
            w_flag_code = pfe_pkg::ST_DIVZERO;
        end else if (i_cmd.push && w_sp_full) begin
            w_flag_en   = 1'b1;
            w_flag_code = pfe_pkg::ST_OVERFLOW;
        end else begin
            w_flag_en   = 1'b0;
        end
    end

    // magnitudes for the divider, most negative input maps to 2^31
    assign w_mag_a     = r_a[31] ? (~r_a + 32'd1) : r_a;
    assign w_mag_b     = r_b[31] ? (~r_b + 32'd1) : r_b;
    assign w_div_start = i_cmd.exec && (w_kind == pfe_pkg::TK_DIV) && !w_b_zero;

    pfe_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (DW'(w_mag_a) << FRAC_BITS),
        .i_divisor  (w_mag_b),
        .o_quotient (w_quo),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done)
    );

    // product scaled down, rounding toward zero
    assign w_mul_sh = (r_prod + (r_prod[63] ? BIAS : 64'sd0)) >>> FRAC_BITS;
    assign w_qs     = $signed(64'(w_quo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_err       <= pfe_pkg::ST_OK;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_sp   <= '0;
                r_err  <= pfe_pkg::ST_OK;
                r_skip <= 1'b0;
            end else begin
                if (w_flag_en && r_err == pfe_pkg::ST_OK) begin
                    r_err <= w_flag_code;
                end
                if (i_cmd.unknown) begin
                    r_skip <= 1'b1;
                end
                if (i_cmd.pop && !w_sp_empty) begin
                    r_sp <= w_spm1;
                end else if (i_cmd.push && !w_sp_full) begin
                    r_sp <= r_sp + SPW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tok  <= i_token;
            r_last <= i_last;
        end
        if (i_cmd.pop) begin
            r_empty <= w_sp_empty;
            if (!w_sp_empty) begin
                r_rdata <= r_mem[w_spm1[AW-1:0]];
            end
        end
        if (i_cmd.load_b) begin
            r_b <= r_empty ? 32'sd0 : r_rdata;
        end
        if (i_cmd.load_a) begin
            r_a <= r_empty ? 32'sd0 : r_rdata;
        end
        if (i_cmd.exec) begin
            r_neg <= r_a[31] ^ r_b[31];
        end
        priority if (i_cmd.load_digit) begin
            r_res <= $signed(32'(w_off[3:0]) << FRAC_BITS);
        end else if (i_cmd.load_top) begin
            r_res <= r_empty ? 32'sd0 : r_rdata;
        end else if (i_cmd.exec) begin
            unique case (w_kind)
                pfe_pkg::TK_ADD: r_res <= pfe_pkg::sat32(64'(r_a) + 64'(r_b));
                pfe_pkg::TK_SUB: r_res <= pfe_pkg::sat32(64'(r_a) - 64'(r_b));
                pfe_pkg::TK_MUL: r_prod <= r_a * r_b;
                default:         r_res <= 32'sd0; // divide by zero result
            endcase
        end else if (i_cmd.mul_fin) begin
            r_res <= pfe_pkg::sat32(w_mul_sh);
        end else if (i_cmd.div_fin) begin
            r_res <= pfe_pkg::sat32(r_neg ? -w_qs : w_qs);
        end else begin
            r_res <= r_res;
        end
        if (i_cmd.out_load) begin
            r_out_value  <= r_skip ? 32'sd0 : r_res;
            r_out_status <= r_err;
        end
    end

    // stack memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !w_sp_full) begin
            r_mem[r_sp[AW-1:0]] <= r_res;
        end
    end

    always_comb begin
        o_sts.kind     = w_kind;
        o_sts.last     = r_last;
        o_sts.skipping = r_skip;
        o_sts.b_zero   = w_b_zero;
        o_sts.div_busy = w_div_busy;
        o_sts.div_done = w_div_done;
        o_sts.out_full = r_out_valid;
        o_sts.sp_empty = w_sp_empty;
        o_sts.sp_full  = w_sp_full;
    end

    assign o_value     = r_out_value;
    assign o_status    = r_out_status;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> rtl/core/pfe_ctrl.sv
// controller state machine sequencing each character through the datapath
// depends on pfe_pkg
`default_nettype none

module pfe_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire pfe_pkg::t_dp_sts i_sts,
    output pfe_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_B,
        S_LD_B,
        S_POP_A,
        S_LD_A,
        S_EXEC,
        S_MUL,
        S_DIV_WAIT,
        S_DIV_FIN,
        S_PUSH,
        S_END,
        S_FPOP,
        S_FLD,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.skipping) begin
                    n_state = S_END;
                end else begin
                    unique case (i_sts.kind)
                        pfe_pkg::TK_DIGIT: begin
                            o_cmd.load_digit = 1'b1;
                            n_state = S_PUSH;
                        end
                        pfe_pkg::TK_BAD: begin
                            o_cmd.unknown = 1'b1;
                            n_state = S_END;
                        end
                        default: n_state = S_POP_B;
                    endcase
                end
            end
            S_POP_B: begin
                o_cmd.pop = 1'b1;
                n_state = S_LD_B;
            end
            S_LD_B: begin
                o_cmd.load_b = 1'b1;
                n_state = S_POP_A;
            end
            S_POP_A: begin
                o_cmd.pop = 1'b1;
                n_state = S_LD_A;
            end
            S_LD_A: begin
                o_cmd.load_a = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                priority if (i_sts.kind == pfe_pkg::TK_MUL) begin
                    n_state = S_MUL;
                end else if (i_sts.kind == pfe_pkg::TK_DIV && !i_sts.b_zero) begin
                    n_state = S_DIV_WAIT;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_MUL: begin
                o_cmd.mul_fin = 1'b1;
                n_state = S_PUSH;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_DIV_FIN;
                end
            end
            S_DIV_FIN: begin
                o_cmd.div_fin = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state = S_END;
            end
            S_END: begin
                priority if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (i_sts.skipping) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_FPOP;
                end
            end
            S_FPOP: begin
                o_cmd.pop = 1'b1;
                n_state = S_FLD;
            end
            S_FLD: begin
                o_cmd.load_top = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/postfix_expression_evaluator.sv
// top level of the postfix (reverse polish) expression evaluator
// depends on pfe_pkg, pfe_ctrl, pfe_dp (which holds pfe_div)
`default_nettype none

// Evaluates a postfix expression sent one ascii character per input word, with
// s_axis_tlast on the final character. Digits '0'..'9' push their value in signed
// fixed point with FRAC_BITS fraction bits (Q16.16 by default); + - * / pop the
// right then the left operand and push the result. Add, subtract, multiply and
// divide saturate to 32 bits, multiply and divide truncate toward zero. The last
// character yields one output word: the popped top of stack in m_axis_tdata and a
// status code in m_axis_tuser (0 ok, 1 unknown character, 2 underflow, 3 divide
// by zero, 4 overflow). Status is sticky, the first error of an expression wins;
// after an unknown character the rest of the expression is ignored and the value
// is 0. A missing operand reads as 0, a push onto a full stack is dropped. The
// stack and status clear after each expression; no clearing pass is needed after
// reset. One character is in work at a time, counted from its accept to the next
// ready: a digit is decoded and pushed; + - * / pop the right then the left
// operand, run and push; * adds a scaling step, / by nonzero waits for the divider
// (one quotient bit per cycle over 32+FRAC_BITS bits) and then fixes the sign. The
// last character adds a final pop and output load (only the output load once an
// unknown character was seen), and the load waits while the previous word is still
// in the output register. The finished word sits in an output register, so the
// next expression can start while it waits to be taken.

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 16,  // 2 to 256 operands
    parameter int FRAC_BITS   = 16   // 0 to 24 fraction bits
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input characters
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] token
    input  wire logic        s_axis_tlast,   // last character of the expression
    // results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic signed [31:0] m_axis_tdata, // [31:0] value, signed fixed point
    output logic [2:0]       m_axis_tuser    // [2:0] status
);

    pfe_pkg::t_dp_cmd w_cmd;
    pfe_pkg::t_dp_sts w_sts;

    // sequencer: one state per datapath step
    pfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // stack, alu, divider and output register
    pfe_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_token     (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_value     (m_axis_tdata),
        .o_status    (m_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    // the divider only runs while the controller waits in the middle of a word
    a_div_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_sts.div_busy)
        else $error("divider busy while accepting a new word");

    // the stack never reads as both empty and full
    a_sp_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_sts.sp_empty && w_sts.sp_full))
        else $error("stack pointer both empty and full");

    // loading the output word presents it and leaves an empty stack
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> (m_axis_tvalid && w_sts.sp_empty && !w_sts.skipping))
        else $error("output load did not present the word or clear the stack");

    // status codes stay in the defined range
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= pfe_pkg::ST_OVERFLOW))
        else $error("undefined status code on output");

endmodule

`default_nettype wire
